@@ rtl/smpq_pkg.sv @@
// shared types and constants for the stable min priority queue
`timescale 1ns / 1ps
`default_nettype none
package smpq_pkg;

	localparam int DEPTH     = 16;
	localparam int PRIO_BITS = 16;
	localparam int DATA_BITS = 32;
	localparam int FILL_W    = $clog2(DEPTH + 1);

	localparam logic [1:0] CMD_ENQ  = 2'd0;
	localparam logic [1:0] CMD_DEQ  = 2'd1;
	localparam logic [1:0] CMD_PEEK = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [15:0] prio_in;
		logic [31:0]        data_in;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [31:0]        data_out;
		logic signed [15:0] prio_out;
		logic [4:0]         count;
	} rsp_t;

	typedef struct packed {
		logic signed [PRIO_BITS-1:0] prio;
		logic [DATA_BITS-1:0]        data;
	} entry_t;

	typedef struct packed {
		logic enq;
		logic deq;
	} cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/smpq_cell.sv @@
// one slot of the sorted queue: holds an entry and shifts or inserts with its neighbours
`timescale 1ns / 1ps
`default_nettype none
module smpq_cell
	import smpq_pkg::*;
(
	input  wire logic       clk,
	input  wire cell_ctrl_t ctrl,
	input  wire entry_t     new_entry,
	input  wire entry_t     left_entry,
	input  wire entry_t     right_entry,
	input  wire logic       left_keep,
	input  wire logic       occ,
	output entry_t          entry,
	output logic            keep
);

	entry_t entry_q;

	// entry stays put when it is occupied and not after the new priority
	assign keep  = occ && (entry_q.prio <= new_entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (!keep) begin
				entry_q <= left_keep ? new_entry : left_entry;
			end
		end else if (ctrl.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule
`default_nettype wire

@@ rtl/stable_min_priority_queue.sv @@
// top level of the stable min priority queue built from a row of sorted slots
//
// Usage: a command beat is taken at a rising edge where start is high and
// busy is low; busy is never raised, so one command may be issued in every
// cycle. The command selects enqueue, dequeue of the head or peek of the
// head. Exactly one result beat follows for each command, in the cycle after it
// is taken, marked by done for a single cycle; the receiver cannot stall.
// One command is taken per cycle, since every slot
// compares its priority with the new one in parallel and takes its own,
// its left or its right neighbour's entry in the same edge.
// Equal priorities leave in arrival order. An enqueue to a full queue is
// dropped with status full; dequeue or peek of an empty queue gives status
// empty with zero data and priority. count is the fill after the command.
// Reset clears the fill count and done; slot contents are not cleared and
// are never read before they are written.
`timescale 1ns / 1ps
`default_nettype none
module stable_min_priority_queue
	import smpq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output rsp_t      rsp
);

	logic [FILL_W-1:0] fill_q;
	logic              done_q;
	rsp_t              rsp_q;

	entry_t            new_entry;
	entry_t            cell_q [DEPTH];
	logic              keep   [DEPTH];
	logic              accept;
	logic              full;
	logic              empty;
	cell_ctrl_t        ctrl;
	rsp_t              rsp_d;
	logic [FILL_W-1:0] fill_d;
	entry_t            head;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (fill_q == FILL_W'(DEPTH));
	assign empty  = (fill_q == '0);
	assign head   = cell_q[0];

	assign new_entry.prio = PRIO_BITS'(req.prio_in);
	assign new_entry.data = DATA_BITS'(req.data_in);

	always_comb begin
		ctrl           = '0;
		fill_d         = fill_q;
		rsp_d.status   = ST_OK;
		rsp_d.data_out = '0;
		rsp_d.prio_out = '0;
		case (req.cmd)
			CMD_ENQ: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					ctrl.enq = accept;
					fill_d   = fill_q + 1'b1;
				end
			end
			CMD_DEQ, CMD_PEEK: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					rsp_d.data_out = 32'(head.data);
					rsp_d.prio_out = 16'(head.prio);
					if (req.cmd == CMD_DEQ) begin
						ctrl.deq = accept;
						fill_d   = fill_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		rsp_d.count = 5'(fill_d);
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [FILL_W-1:0] IDX = FILL_W'(i);
		entry_t left_entry;
		entry_t right_entry;
		logic   left_keep;

		if (i == 0) begin : g_first
			assign left_entry = new_entry;
			assign left_keep  = 1'b1;
		end else begin : g_mid
			assign left_entry = cell_q[i-1];
			assign left_keep  = keep[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_entry = cell_q[i];
		end else begin : g_inner
			assign right_entry = cell_q[i+1];
		end

		smpq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.new_entry  (new_entry),
			.left_entry (left_entry),
			.right_entry(right_entry),
			.left_keep  (left_keep),
			.occ        (IDX < fill_q),
			.entry      (cell_q[i]),
			.keep       (keep[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				fill_q <= fill_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(DEPTH))
		else $error("fill beyond depth");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("command without result");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_FULL |-> rsp.count == 5'(DEPTH))
		else $error("full status with wrong count");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_EMPTY |-> rsp.count == '0 && rsp.data_out == '0)
		else $error("empty status with non-zero fields");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(fill_q))
		else $error("fill changed without command");

endmodule
`default_nettype wire

@@ dv/smpq_checker.sv @@
`timescale 1ns / 1ps
// checker for the priority queue: tracks queue contents, predicts each result beat and compares
module smpq_checker
	import smpq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic busy,
	input  wire req_t req,
	input  wire logic done,
	input  wire rsp_t rsp,
	output int        fails,
	output int        pending
);

	logic signed [PRIO_BITS-1:0] slot_prio [DEPTH];
	logic [DATA_BITS-1:0]        slot_data [DEPTH];
	int                          held;
	rsp_t                        awaited_rsp [$];
	rsp_t                        want;

	initial begin
		fails   = 0;
		pending = 0;
		held    = 0;
	end

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $time, what);
		fails++;
	endtask

	// applies one command to the tracked queue and returns the result beat it should give
	function automatic rsp_t serve_command(input req_t r);
		rsp_t                        o;
		int                          pos;
		logic signed [PRIO_BITS-1:0] p;
		o = '0;
		p = r.prio_in;
		case (r.cmd)
			CMD_ENQ: begin
				if (held >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					pos = 0;
					// equal priorities stay behind earlier arrivals
					while (pos < held && slot_prio[pos] <= p)
						pos++;
					for (int i = held; i > pos; i--) begin
						slot_prio[i] = slot_prio[i-1];
						slot_data[i] = slot_data[i-1];
					end
					slot_prio[pos] = p;
					slot_data[pos] = r.data_in;
					held++;
				end
			end
			CMD_DEQ, CMD_PEEK: begin
				if (held == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.data_out = slot_data[0];
					o.prio_out = slot_prio[0];
					if (r.cmd == CMD_DEQ) begin
						for (int i = 1; i < held; i++) begin
							slot_prio[i-1] = slot_prio[i];
							slot_data[i-1] = slot_data[i];
						end
						held--;
					end
				end
			end
			default: ;
		endcase
		o.count = 5'(held);
		return o;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (awaited_rsp.size() == 0) begin
					report("result beat with no command outstanding");
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.status !== want.status)
						report($sformatf("status got %0d want %0d", rsp.status, want.status));
					if (rsp.data_out !== want.data_out)
						report($sformatf("data_out got %h want %h", rsp.data_out,
							want.data_out));
					if (rsp.prio_out !== want.prio_out)
						report($sformatf("prio_out got %0d want %0d", rsp.prio_out,
							want.prio_out));
					if (rsp.count !== want.count)
						report($sformatf("count got %0d want %0d", rsp.count, want.count));
				end
			end
			if (start && !busy)
				awaited_rsp.push_back(serve_command(req));
			pending <= awaited_rsp.size();
		end
	end

endmodule

@@ dv/tb_stable_min_priority_queue.sv @@
`timescale 1ns / 1ps
// testbench top for the priority queue: clock, reset, command stimulus and verdict
module tb_stable_min_priority_queue;
	import smpq_pkg::*;

	localparam logic [1:0] CMD_NOP     = 2'd3;
	localparam int         N_ITEMS     = 1950;
	localparam int         N_DIRECTED  = 22;
	localparam int         CYCLE_LIMIT = 40000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t rsp;
	int   fails;
	int   pending;
	int   cycles = 0;
	int   mode;
	bit   narrow;

	stable_min_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	smpq_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.rsp     (rsp),
		.fails   (fails),
		.pending (pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic issue(input logic [1:0] c, input logic [15:0] p, input logic [31:0] d);
		req_t r;
		r.cmd     = c;
		r.prio_in = p;
		r.data_in = d;
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_cycle();
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] pick_prio(input bit close);
		int k;
		k = $urandom_range(99);
		if (k < 4)
			return 16'h8000;
		if (k < 8)
			return 16'h7fff;
		if (close)
			return 16'(int'($urandom_range(6)) - 3);
		return 16'($urandom);
	endfunction

	// mode 0 leans to filling, mode 1 to draining, mode 2 is balanced
	task automatic random_beat();
		int         k;
		int         enq_pct;
		int         deq_pct;
		logic [1:0] c;
		enq_pct = (mode == 0) ? 75 : (mode == 1) ? 20 : 45;
		deq_pct = (mode == 0) ? 12 : (mode == 1) ? 65 : 40;
		k = $urandom_range(99);
		if (k < enq_pct)
			c = CMD_ENQ;
		else if (k < enq_pct + deq_pct)
			c = CMD_DEQ;
		else if (k < 99)
			c = CMD_PEEK;
		else
			c = CMD_NOP;
		issue(c, pick_prio(narrow), $urandom);
	endtask

	initial begin
		start  = 1'b0;
		req    = '0;
		arst_n = 1'b0;
		mode   = 2;
		narrow = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// empty queue and the unused code
		issue(CMD_DEQ,  16'h0000, 32'h0000_0000);
		issue(CMD_PEEK, 16'h1234, 32'hffff_ffff);
		issue(CMD_NOP,  16'hffff, 32'hffff_ffff);
		// priority extremes and ties
		issue(CMD_ENQ,  16'h7fff, 32'hffff_ffff);
		issue(CMD_ENQ,  16'h8000, 32'h0000_0000);
		issue(CMD_ENQ,  16'h0000, 32'ha5a5_a5a5);
		issue(CMD_ENQ,  16'h0000, 32'h5a5a_5a5a);
		issue(CMD_ENQ,  16'hffff, 32'h0000_0001);
		issue(CMD_ENQ,  16'h8000, 32'h0000_0002);
		issue(CMD_ENQ,  16'h7fff, 32'h0000_0003);
		issue(CMD_PEEK, 16'h0000, 32'h0000_0000);
		repeat (3) issue(CMD_DEQ, 16'h0000, 32'h0000_0000);
		issue(CMD_PEEK, 16'h0000, 32'h0000_0000);
		issue(CMD_NOP,  16'h0000, 32'h0000_0000);
		repeat (4) issue(CMD_DEQ, 16'h0000, 32'h0000_0000);
		issue(CMD_DEQ,  16'h0000, 32'h0000_0000);
		issue(CMD_PEEK, 16'h0000, 32'h0000_0000);

		for (int n = 0; n < N_ITEMS - N_DIRECTED; n++) begin
			if (n % 40 == 0) begin
				mode   = $urandom_range(2);
				narrow = 1'($urandom_range(1));
			end
			if (n == 900)
				wait_drained();
			else if (!(n >= 1200 && n < 1500) && $urandom_range(99) < 13)
				idle_cycle();
			random_beat();
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
